[rtl/fire_pixel_shader_defines.svh]
// Assertion helpers for the fire pixel shader.
`ifndef FIRE_PIXEL_SHADER_DEFINES_SVH
`define FIRE_PIXEL_SHADER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fps_pkg.sv]
`timescale 1ns / 1ps
package fps_pkg;

  localparam int PANEL_SIDE = 8;
  localparam int SIDE_COUNT = 4;
  localparam int COORD_W    = $clog2(PANEL_SIDE);
  localparam int FACE_W     = $clog2(SIDE_COUNT);
  localparam logic [COORD_W-1:0] PANEL_MAX = COORD_W'(PANEL_SIDE - 1);

  // Configuration register indexes
  localparam logic [2:0] CFG_COOLING       = 3'd0;
  localparam logic [2:0] CFG_SATURATION    = 3'd1;
  localparam logic [2:0] CFG_ROTATION      = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_CORNER = 3'd3;
  localparam logic [2:0] CFG_SERPENTINE    = 3'd4;
  localparam logic [2:0] CFG_COLUMN_MAJOR  = 3'd5;

  // Rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // HSV sectors
  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;

  typedef struct packed {
    logic [1:0] face;
    logic [2:0] column;
    logic [2:0] flame_row;
    logic [7:0] heat_now;
    logic [7:0] heat_below;
    logic [7:0] phase;
    logic [7:0] value_mask;
    logic [7:0] hue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_out_t;

  typedef struct packed {
    logic [1:0] rotation;
    logic [1:0] origin_corner;
    logic       serpentine;
    logic       column_major;
  } map_cfg_t;

endpackage

[rtl/fps_map.sv]
`timescale 1ns / 1ps
// LED chain position of one side-face pixel.
module fps_map (
  input  fps_pkg::map_cfg_t        map_cfg,
  input  logic [1:0]               face,
  input  logic [2:0]               column,
  input  logic [2:0]               flame_row,
  output logic [7:0]               led_index
);

  logic [fps_pkg::COORD_W-1:0]   ry;
  logic [fps_pkg::COORD_W-1:0]   rx_rot;
  logic [fps_pkg::COORD_W-1:0]   ry_rot;
  logic [fps_pkg::COORD_W-1:0]   px;
  logic [fps_pkg::COORD_W-1:0]   py;
  logic [fps_pkg::COORD_W-1:0]   line_sel;
  logic [fps_pkg::COORD_W-1:0]   pos_sel;
  logic [2*fps_pkg::COORD_W-1:0] offset;

  always_comb begin
    // flame row 0 sits at the bottom of the panel
    ry = fps_pkg::PANEL_MAX - flame_row;

    unique case (map_cfg.rotation)
      fps_pkg::ROT_90: begin
        rx_rot = fps_pkg::PANEL_MAX - ry;
        ry_rot = column;
      end
      fps_pkg::ROT_180: begin
        rx_rot = fps_pkg::PANEL_MAX - column;
        ry_rot = fps_pkg::PANEL_MAX - ry;
      end
      fps_pkg::ROT_270: begin
        rx_rot = ry;
        ry_rot = fps_pkg::PANEL_MAX - column;
      end
      default: begin
        rx_rot = column;
        ry_rot = ry;
      end
    endcase

    px = map_cfg.origin_corner[0] ? fps_pkg::PANEL_MAX - rx_rot : rx_rot;
    py = map_cfg.origin_corner[1] ? fps_pkg::PANEL_MAX - ry_rot : ry_rot;

    // chain line and position along it
    line_sel = map_cfg.column_major ? px : py;
    pos_sel  = map_cfg.column_major ? py : px;
    if (map_cfg.serpentine && line_sel[0]) begin
      pos_sel = fps_pkg::PANEL_MAX - pos_sel;
    end

    offset    = {line_sel, pos_sel};
    led_index = {face, offset};
  end

endmodule

[rtl/fire_pixel_shader.sv]
`timescale 1ns / 1ps
// Fire pixel shader: shades one flame cell of a side face of an LED cube.
// Input channel in_valid/in_ready/in_data carries one pixel request (face,
// column, flame row, heats, phase, cooling mask, hue). Output channel
// out_valid/out_ready/out_data returns the LED chain index and RGB levels.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes cooling,
// saturation, rotation, origin corner, serpentine and column-major; it is
// always ready and should be written only while the shader is drained.
// Throughput: one pixel per clock while out_ready is high, set by a
// four-stage pipeline (blend and position, clamp and saturation terms,
// HSV products, sector select and output register). An accepted pixel
// moves through stages 1, 2 and 3 into the stage 4 register on out_data.
// Reset clears all stage valid bits and loads the register defaults:
// cooling 64, saturation 255, rotation 0, origin 0, serpentine 1,
// column-major 1. When out_ready is low the output stage holds; the
// stages behind it keep filling bubbles, and in_ready drops only once
// all four stages are full.
module fire_pixel_shader (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fps_pkg::pixel_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fps_pkg::pixel_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

`include "fire_pixel_shader_defines.svh"

  // Configuration registers
  logic [7:0]        cooling_r;
  logic [7:0]        saturation_r;
  fps_pkg::map_cfg_t map_cfg_r;

  // Stage advance enables
  logic adv1, adv2, adv3, adv4;

  // Stage 1: blend, mask subtraction term, hue split, chain index
  logic        s1_vld_r;
  logic [7:0]  s1_blend_r;
  logic [9:0]  s1_sub_r;
  logic [2:0]  s1_sector_r;
  logic [7:0]  s1_frac_r;
  logic [7:0]  s1_idx_r;
  logic [8:0]  inv_phase;
  logic [16:0] blend_sum;
  logic [15:0] mask_prod;
  logic [10:0] hue6;
  logic [7:0]  led_index_nxt;

  // Stage 2: clamped value and saturation factors
  logic        s2_vld_r;
  logic [7:0]  s2_val_r;
  logic [8:0]  s2_kp_r, s2_kq_r, s2_kt_r;
  logic        s2_grey_r;
  logic [2:0]  s2_sector_r;
  logic [7:0]  s2_idx_r;
  logic [10:0] diff;
  logic [7:0]  val_nxt;
  logic [15:0] sf_prod;
  logic [8:0]  inv_frac;
  logic [16:0] sg_prod;

  // Stage 3: p, q, t
  logic        s3_vld_r;
  logic [7:0]  s3_val_r, s3_p_r, s3_q_r, s3_t_r;
  logic        s3_grey_r;
  logic [2:0]  s3_sector_r;
  logic [7:0]  s3_idx_r;
  logic [16:0] p_prod, q_prod, t_prod;

  // Stage 4: output register
  logic                s4_vld_r;
  logic                s4_grey_r;
  fps_pkg::pixel_out_t s4_data_r;
  logic [7:0]          r_sel, g_sel, b_sel;

  // Advance a stage when it is empty or the one after it moves
  assign adv4      = !s4_vld_r || out_ready;
  assign adv3      = !s3_vld_r || adv4;
  assign adv2      = !s2_vld_r || adv3;
  assign adv1      = !s1_vld_r || adv2;
  assign in_ready  = adv1;
  assign cfg_ready = 1'b1;
  assign out_valid = s4_vld_r;
  assign out_data  = s4_data_r;

  // Config write; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooling_r                <= 8'd64;
      saturation_r             <= 8'd255;
      map_cfg_r.rotation       <= fps_pkg::ROT_0;
      map_cfg_r.origin_corner  <= 2'd0;
      map_cfg_r.serpentine     <= 1'b1;
      map_cfg_r.column_major   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fps_pkg::CFG_COOLING:       cooling_r               <= cfg_data;
        fps_pkg::CFG_SATURATION:    saturation_r            <= cfg_data;
        fps_pkg::CFG_ROTATION:      map_cfg_r.rotation      <= cfg_data[1:0];
        fps_pkg::CFG_ORIGIN_CORNER: map_cfg_r.origin_corner <= cfg_data[1:0];
        fps_pkg::CFG_SERPENTINE:    map_cfg_r.serpentine    <= cfg_data[0];
        fps_pkg::CFG_COLUMN_MAJOR:  map_cfg_r.column_major  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- Stage 1 ----------------
  fps_map u_map (
    .map_cfg   (map_cfg_r),
    .face      (in_data.face),
    .column    (in_data.column),
    .flame_row (in_data.flame_row),
    .led_index (led_index_nxt)
  );

  always_comb begin
    inv_phase = 9'd256 - {1'b0, in_data.phase};
    // heat blended by phase; sum never exceeds 16 bits
    blend_sum = ({8'd0, inv_phase} * {9'd0, in_data.heat_now})
              + {1'b0, {8'd0, in_data.phase} * {8'd0, in_data.heat_below}};
    mask_prod = {8'd0, in_data.value_mask} * {8'd0, cooling_r};
    hue6      = {3'd0, in_data.hue} * 11'd6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv1) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_blend_r  <= blend_sum[15:8];
      s1_sub_r    <= mask_prod[15:6];
      s1_sector_r <= hue6[10:8];
      s1_frac_r   <= hue6[7:0];
      s1_idx_r    <= led_index_nxt;
    end
  end

  // ---------------- Stage 2 ----------------
  always_comb begin
    diff = {3'd0, s1_blend_r} - {1'b0, s1_sub_r};
    // clamp to 0..255
    if (diff[10]) begin
      val_nxt = 8'd0;
    end else if (diff[9:8] != 2'd0) begin
      val_nxt = 8'd255;
    end else begin
      val_nxt = diff[7:0];
    end
    sf_prod  = {8'd0, saturation_r} * {8'd0, s1_frac_r};
    inv_frac = 9'd256 - {1'b0, s1_frac_r};
    sg_prod  = {9'd0, saturation_r} * {8'd0, inv_frac};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_val_r    <= val_nxt;
      s2_kp_r     <= 9'd256 - {1'b0, saturation_r};
      s2_kq_r     <= 9'd256 - {1'b0, sf_prod[15:8]};
      s2_kt_r     <= 9'd256 - {1'b0, sg_prod[15:8]};
      s2_grey_r   <= (saturation_r == 8'd0);
      s2_sector_r <= s1_sector_r;
      s2_idx_r    <= s1_idx_r;
    end
  end

  // ---------------- Stage 3 ----------------
  always_comb begin
    p_prod = {9'd0, s2_val_r} * {8'd0, s2_kp_r};
    q_prod = {9'd0, s2_val_r} * {8'd0, s2_kq_r};
    t_prod = {9'd0, s2_val_r} * {8'd0, s2_kt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv3) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_val_r    <= s2_val_r;
      s3_p_r      <= p_prod[15:8];
      s3_q_r      <= q_prod[15:8];
      s3_t_r      <= t_prod[15:8];
      s3_grey_r   <= s2_grey_r;
      s3_sector_r <= s2_sector_r;
      s3_idx_r    <= s2_idx_r;
    end
  end

  // ---------------- Stage 4 ----------------
  // (x*255)>>8 equals x-1 for nonzero x
  function automatic logic [7:0] scale_level(input logic [7:0] x);
    scale_level = (x == 8'd0) ? 8'd0 : x - 8'd1;
  endfunction

  always_comb begin
    if (s3_grey_r) begin
      r_sel = s3_val_r;
      g_sel = s3_val_r;
      b_sel = s3_val_r;
    end else begin
      unique case (s3_sector_r)
        fps_pkg::SEC_RED_YEL: begin
          r_sel = s3_val_r; g_sel = s3_t_r;   b_sel = s3_p_r;
        end
        fps_pkg::SEC_YEL_GRN: begin
          r_sel = s3_q_r;   g_sel = s3_val_r; b_sel = s3_p_r;
        end
        fps_pkg::SEC_GRN_CYN: begin
          r_sel = s3_p_r;   g_sel = s3_val_r; b_sel = s3_t_r;
        end
        fps_pkg::SEC_CYN_BLU: begin
          r_sel = s3_p_r;   g_sel = s3_q_r;   b_sel = s3_val_r;
        end
        fps_pkg::SEC_BLU_MAG: begin
          r_sel = s3_t_r;   g_sel = s3_p_r;   b_sel = s3_val_r;
        end
        default: begin
          r_sel = s3_val_r; g_sel = s3_p_r;   b_sel = s3_q_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv4) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_grey_r           <= s3_grey_r;
      s4_data_r.led_index <= s3_idx_r;
      s4_data_r.red       <= scale_level(r_sel);
      s4_data_r.green     <= scale_level(g_sel);
      s4_data_r.blue      <= scale_level(b_sel);
    end
  end

  // ---------------- Checks ----------------
  `FPS_CHECK(a_full_blocks_in,
             s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && !out_ready,
             !in_ready, "full pipeline still takes a request")
  `FPS_CHECK_NEXT(a_no_drop_s2, s1_vld_r && adv2, s2_vld_r,
                  "request lost between stage 1 and 2")
  `FPS_CHECK(a_grey_equal, s4_vld_r && s4_grey_r,
             out_data.red == out_data.green && out_data.green == out_data.blue,
             "grey pixel has unequal channels")

endmodule
